// File: sv/lca_pkg.sv
// Shared types and constants for the Life grid unit.
// Used by every module and interface of the block; depends on nothing.
`default_nettype none

package lca_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;

  localparam int ROW_AW = $clog2(MAX_HEIGHT);
  localparam int COL_W  = 6;
  localparam int ROWF_W = 6;
  localparam int SIZE_W = 7;
  localparam int GEN_W  = 32;
  localparam int CFG_IW = 1;

  localparam logic [SIZE_W-1:0] MAX_W_SZ = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] MAX_H_SZ = SIZE_W'(MAX_HEIGHT);
  localparam logic [SIZE_W-1:0] RESET_SZ = SIZE_W'(64);

  typedef logic [MAX_WIDTH-1:0] row_t;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_CLEAR   = 2'd3
  } lca_op_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } lca_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ACCESS,
    ST_ADV_LOAD,
    ST_ADV_ROW,
    ST_FINISH
  } lca_state_t;

  typedef struct packed {
    logic take_in;
    logic clear_all;
    logic gen_inc;
    logic rd_cell;
    logic cell_acc;
    logic adv_start;
    logic adv_load;
    logic adv_row;
    logic out_load;
  } lca_ctl_t;

  typedef struct packed {
    lca_op_t op;
    logic    in_bounds;
    logic    size_zero;
    logic    adv_last;
    logic    out_free;
  } lca_sts_t;

endpackage

`default_nettype wire

// File: sv/lca_in_if.sv
// Command channel carrying one grid command per transaction.
// Depends on lca_pkg for field widths.
`default_nettype none

interface lca_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 cmd;
  logic [lca_pkg::COL_W-1:0]  col;
  logic [lca_pkg::ROWF_W-1:0] row;
  logic                       cell_value;

  modport source (output valid, cmd, col, row, cell_value, input ready);
  modport sink   (input valid, cmd, col, row, cell_value, output ready);
endinterface

`default_nettype wire

// File: sv/lca_out_if.sv
// Result channel carrying one response per command transaction.
// Depends on lca_pkg for field widths.
`default_nettype none

interface lca_out_if;
  logic                      valid;
  logic                      ready;
  logic                      read_value;
  logic                      out_of_range;
  logic [lca_pkg::GEN_W-1:0] generation;

  modport source (output valid, read_value, out_of_range, generation, input ready);
  modport sink   (input valid, read_value, out_of_range, generation, output ready);
endinterface

`default_nettype wire

// File: sv/lca_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on lca_pkg for field widths.
`default_nettype none

interface lca_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lca_pkg::CFG_IW-1:0] index;
  logic [lca_pkg::SIZE_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/lca_row_rule.sv
// Next-generation logic for one grid row from its window of three rows.
// Depends on lca_pkg for the row type.
`default_nettype none

module lca_row_rule (
  input  lca_pkg::row_t prev_row,
  input  lca_pkg::row_t cur_row,
  input  lca_pkg::row_t next_row,
  input  lca_pkg::row_t col_mask,
  output lca_pkg::row_t new_row
);

  lca_pkg::row_t nb_prev, nb_cur, nb_next;
  lca_pkg::row_t born;

  assign nb_prev = prev_row;
  assign nb_cur  = cur_row;
  assign nb_next = next_row;

  always_comb begin
    logic [3:0] n;
    born = '0;
    for (int x = 0; x < lca_pkg::MAX_WIDTH; x++) begin
      n = {3'd0, nb_prev[x]} + {3'd0, nb_next[x]};
      if (x > 0) begin
        n = n + {3'd0, nb_prev[x-1]} + {3'd0, nb_cur[x-1]} + {3'd0, nb_next[x-1]};
      end
      if (x < lca_pkg::MAX_WIDTH - 1) begin
        n = n + {3'd0, nb_prev[x+1]} + {3'd0, nb_cur[x+1]} + {3'd0, nb_next[x+1]};
      end
      born[x] = (n == 4'd3) || (nb_cur[x] && (n == 4'd2));
    end
  end

  assign new_row = born & col_mask;

endmodule

`default_nettype wire

// File: sv/lca_ctrl.sv
// Command sequencer for the Life grid unit.
// Depends on lca_pkg for the state, command and status types.
`default_nettype none

module lca_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lca_pkg::lca_sts_t sts,
  output lca_pkg::lca_ctl_t ctl
);

  lca_pkg::lca_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lca_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lca_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = lca_pkg::ST_DECODE;
      end
      lca_pkg::ST_DECODE: begin
        case (sts.op)
          lca_pkg::CMD_WRITE, lca_pkg::CMD_READ: begin
            state_nxt = sts.in_bounds ? lca_pkg::ST_ACCESS : lca_pkg::ST_FINISH;
          end
          lca_pkg::CMD_ADVANCE: begin
            state_nxt = sts.size_zero ? lca_pkg::ST_FINISH : lca_pkg::ST_ADV_LOAD;
          end
          default: state_nxt = lca_pkg::ST_FINISH;
        endcase
      end
      lca_pkg::ST_ACCESS:   state_nxt = lca_pkg::ST_FINISH;
      lca_pkg::ST_ADV_LOAD: state_nxt = lca_pkg::ST_ADV_ROW;
      lca_pkg::ST_ADV_ROW: begin
        if (sts.adv_last) state_nxt = lca_pkg::ST_FINISH;
      end
      lca_pkg::ST_FINISH: begin
        if (sts.out_free) state_nxt = lca_pkg::ST_IDLE;
      end
      default: state_nxt = lca_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state_r)
      lca_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.take_in = in_valid;
      end
      lca_pkg::ST_DECODE: begin
        case (sts.op)
          lca_pkg::CMD_WRITE, lca_pkg::CMD_READ: ctl.rd_cell = sts.in_bounds;
          lca_pkg::CMD_ADVANCE: begin
            ctl.gen_inc   = 1'b1;
            ctl.adv_start = !sts.size_zero;
          end
          default: ctl.clear_all = 1'b1;
        endcase
      end
      lca_pkg::ST_ACCESS:   ctl.cell_acc = 1'b1;
      lca_pkg::ST_ADV_LOAD: ctl.adv_load = 1'b1;
      lca_pkg::ST_ADV_ROW:  ctl.adv_row  = 1'b1;
      lca_pkg::ST_FINISH:   ctl.out_load = sts.out_free;
      default: ctl = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/lca_dp.sv
// Datapath: grid memory with row valid bits, row window, generation count,
// size registers and the result register. Depends on lca_pkg, lca_row_rule.
`default_nettype none

module lca_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lca_pkg::lca_ctl_t           ctl,
  output lca_pkg::lca_sts_t           sts,
  input  logic [1:0]                  in_cmd,
  input  logic [lca_pkg::COL_W-1:0]   in_col,
  input  logic [lca_pkg::ROWF_W-1:0]  in_row,
  input  logic                        in_cell_value,
  input  logic                        cfg_we,
  input  logic [lca_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [lca_pkg::SIZE_W-1:0]  cfg_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_read_value,
  output logic                        out_out_of_range,
  output logic [lca_pkg::GEN_W-1:0]   out_generation
);

  localparam int AW = lca_pkg::ROW_AW;
  localparam int SW = lca_pkg::SIZE_W;

  lca_pkg::row_t grid_mem [lca_pkg::MAX_HEIGHT];
  logic [lca_pkg::MAX_HEIGHT-1:0] row_vld_r;

  lca_pkg::row_t rd_data_r;
  logic          rd_vld_r;
  lca_pkg::row_t rd_eff;

  logic [SW-1:0] width_r, height_r;
  logic [SW-1:0] eff_w, eff_h;
  lca_pkg::row_t col_mask;

  lca_pkg::lca_op_t              op_r;
  logic [lca_pkg::COL_W-1:0]     col_r;
  logic [lca_pkg::ROWF_W-1:0]    row_r;
  logic                          val_r;
  logic                          bit_r;

  logic [lca_pkg::GEN_W-1:0]     gen_r;
  logic [AW-1:0]                 y_r;
  lca_pkg::row_t                 prev_r, cur_r;
  lca_pkg::row_t                 nxt_row, new_row, col_bit;

  logic                          rd_en, wr_en;
  logic [AW-1:0]                 rd_addr, wr_addr;
  lca_pkg::row_t                 wr_data;
  logic                          in_bounds;

  logic                          out_valid_r, read_value_r, oor_r;
  logic [lca_pkg::GEN_W-1:0]     gen_out_r;

  assign eff_w = (width_r  > lca_pkg::MAX_W_SZ) ? lca_pkg::MAX_W_SZ : width_r;
  assign eff_h = (height_r > lca_pkg::MAX_H_SZ) ? lca_pkg::MAX_H_SZ : height_r;

  always_comb begin
    for (int x = 0; x < lca_pkg::MAX_WIDTH; x++) begin
      col_mask[x] = SW'(x) < eff_w;
    end
  end

  assign in_bounds = (SW'(col_r) < eff_w) && (SW'(row_r) < eff_h);
  assign rd_eff    = rd_vld_r ? rd_data_r : '0;

  assign sts.op        = op_r;
  assign sts.in_bounds = in_bounds;
  assign sts.size_zero = (eff_w == '0) || (eff_h == '0);
  assign sts.adv_last  = (SW'(y_r) + SW'(1)) == eff_h;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign nxt_row = sts.adv_last ? '0 : (rd_eff & col_mask);
  assign col_bit = lca_pkg::row_t'(1) << col_r;

  lca_row_rule u_rule (
    .prev_row (prev_r),
    .cur_row  (cur_r & col_mask),
    .next_row (nxt_row),
    .col_mask (col_mask),
    .new_row  (new_row)
  );

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = AW'(row_r);
    wr_data = val_r ? (rd_eff | col_bit) : (rd_eff & ~col_bit);
    if (ctl.rd_cell) begin
      rd_en   = 1'b1;
      rd_addr = AW'(row_r);
    end
    if (ctl.adv_start) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end
    if (ctl.adv_load) begin
      rd_en   = 1'b1;
      rd_addr = AW'(1);
    end
    if (ctl.adv_row) begin
      rd_en   = 1'b1;
      rd_addr = y_r + AW'(2);
      wr_en   = 1'b1;
      wr_addr = y_r;
      wr_data = (cur_r & ~col_mask) | new_row;
    end
    if (ctl.cell_acc && (op_r == lca_pkg::CMD_WRITE)) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) grid_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= grid_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r   <= '0;
      rd_vld_r    <= 1'b0;
      gen_r       <= '0;
      width_r     <= lca_pkg::RESET_SZ;
      height_r    <= lca_pkg::RESET_SZ;
      out_valid_r <= 1'b0;
      y_r         <= '0;
    end else begin
      if (rd_en) rd_vld_r <= row_vld_r[rd_addr];
      if (ctl.clear_all) begin
        row_vld_r <= '0;
        gen_r     <= '0;
      end else if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      if (ctl.gen_inc) gen_r <= gen_r + lca_pkg::GEN_W'(1);
      if (cfg_we) begin
        case (lca_pkg::lca_reg_t'(cfg_index))
          lca_pkg::REG_WIDTH:  width_r  <= cfg_data;
          lca_pkg::REG_HEIGHT: height_r <= cfg_data;
          default: width_r <= width_r;
        endcase
      end
      if (ctl.adv_start) y_r <= '0;
      else if (ctl.adv_row) y_r <= y_r + AW'(1);
      if (ctl.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take_in) begin
      op_r  <= lca_pkg::lca_op_t'(in_cmd);
      col_r <= in_col;
      row_r <= in_row;
      val_r <= in_cell_value;
    end
    if (ctl.cell_acc) bit_r <= rd_eff[col_r];
    if (ctl.adv_start) prev_r <= '0;
    if (ctl.adv_load) cur_r <= rd_eff;
    if (ctl.adv_row) begin
      prev_r <= cur_r & col_mask;
      cur_r  <= rd_eff;
    end
    if (ctl.out_load) begin
      read_value_r <= (op_r == lca_pkg::CMD_READ) && in_bounds && bit_r;
      oor_r        <= ((op_r == lca_pkg::CMD_WRITE) || (op_r == lca_pkg::CMD_READ))
                      && !in_bounds;
      gen_out_r    <= gen_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_value   = read_value_r;
  assign out_out_of_range = oor_r;
  assign out_generation   = gen_out_r;

endmodule

`default_nettype wire

// File: sv/life_cellular_automaton_grid_unit.sv
// Top level of the bounded Life grid unit: sequencer plus datapath.
// Depends on lca_pkg, lca_in_if, lca_out_if, lca_cfg_if, lca_ctrl, lca_dp.
//
// Usage:
//   in_ch   takes one command per transaction: write cell, read cell,
//           advance one generation, or clear the grid.
//   out_ch  returns exactly one result per command: read value, out-of-range
//           flag and the generation count after the command.
//   cfg_ch  writes the active width (index 0) and height (index 1); it is
//           always ready; the user must write it only while no command is in flight (not enforced).
// Timing: one command is worked on at a time. An advance with an empty active
//   size skips the grid; otherwise the grid memory is read and written one
//   row per cycle through a three-row window.
// Reset: synchronous, active low; all cells read dead, generation count 0,
//   width and height 64.
// Stall: the result waits in the output register; a finished command holds
//   in its last step until that register is free, then input is taken again.
`default_nettype none

module life_cellular_automaton_grid_unit (
  input  logic      clk,
  input  logic      rst_n,
  lca_in_if.sink    in_ch,
  lca_out_if.source out_ch,
  lca_cfg_if.sink   cfg_ch
);

  lca_pkg::lca_ctl_t ctl;
  lca_pkg::lca_sts_t sts;
  logic              in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  lca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  lca_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .in_cmd           (in_ch.cmd),
    .in_col           (in_ch.col),
    .in_row           (in_ch.row),
    .in_cell_value    (in_ch.cell_value),
    .cfg_we           (cfg_ch.valid),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_read_value   (out_ch.read_value),
    .out_out_of_range (out_ch.out_of_range),
    .out_generation   (out_ch.generation)
  );

endmodule

`default_nettype wire
